### hw/rtl/esst_pkg.sv
// Package for the escape sequence symbol translator.
// Holds the symbol code tables, the result kind and escape phase types, and shared constants.
// No dependencies.
package esst_pkg;

   localparam int TSIZE               = 103;
   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int OUT_LENGTH_BITS     = 16;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_GREEK     = 8'h67;   // 'g'
   localparam logic [7:0] CHAR_GREEK_UP  = 8'h47;   // 'G'
   localparam logic [7:0] CHAR_STAR      = 8'h2a;   // '*'
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z   = 8'h5a;
   localparam logic [7:0] CASE_SHIFT     = 8'h20;   // 'a' - 'A'

   typedef enum logic [1:0] {
      KIND_CHAR    = 2'd0,
      KIND_END     = 2'd1,
      KIND_UNKNOWN = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ESC  = 2'd1,
      PH_CODE = 2'd2
   } phase_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] sym;
   } lookup_type;

   localparam logic [15:0] CODE_ROM [0:TSIZE-1] = '{
      16'h706c, 16'h6372, 16'h6469, 16'h7371, 16'h6664, 16'h6673, 16'h6670, 16'h6678,
      16'h6275, 16'h6f63,
      16'h6761, 16'h6762, 16'h6767, 16'h6764, 16'h6765, 16'h677a, 16'h6779, 16'h6768,
      16'h6769, 16'h676b, 16'h676c, 16'h676d, 16'h676e, 16'h6763, 16'h676f, 16'h6770,
      16'h6772, 16'h6773, 16'h6774, 16'h6775, 16'h6766, 16'h6778, 16'h6771, 16'h6777,
      16'h7370, 16'h6570, 16'h7362, 16'h6562, 16'h6d6b, 16'h7274,
      16'h5833, 16'h5834, 16'h5835, 16'h5836, 16'h5837, 16'h5838, 16'h5839, 16'h5861,
      16'h5862, 16'h5863, 16'h5864, 16'h5865, 16'h5866, 16'h5867, 16'h5868, 16'h5869,
      16'h5870, 16'h5871, 16'h5872, 16'h5873, 16'h5874, 16'h5875, 16'h5876,
      16'h7074, 16'h6973, 16'h746d, 16'h6469, 16'h7e3d, 16'h7064, 16'h6361, 16'h6962,
      16'h6c61, 16'h7261, 16'h6464, 16'h2b2d, 16'h3c3d, 16'h7363, 16'h6862, 16'h6c62,
      16'h6375, 16'h6465, 16'h646c, 16'h6461, 16'h3c2d, 16'h2d3e, 16'h3c3e, 16'h6c69,
      16'h6d6f, 16'h6e6d, 16'h7372, 16'h756c, 16'h726e, 16'h6578, 16'h3e3d, 16'h616c,
      16'h7362, 16'h6473, 16'h6470, 16'h6467, 16'h6e3d, 16'h7370, 16'h696e, 16'h7561
   };

   localparam logic [7:0] SYM_ROM [0:TSIZE-1] = '{
      8'hb0, 8'hb1, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9,
      8'he1, 8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea, 8'heb, 8'hec,
      8'hed, 8'hee, 8'hef, 8'hf0, 8'hf1, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf7, 8'hf8,
      8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95,
      8'h96, 8'h97, 8'h98, 8'h99, 8'h9a, 8'h9b, 8'h9c, 8'h9d, 8'h9e, 8'h9f,
      8'haa, 8'hab, 8'hac, 8'had, 8'hae, 8'haf,
      8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'he0,
      8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a, 8'h8b,
      8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'ha0, 8'ha1, 8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7,
      8'ha8, 8'ha9, 8'haa, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hbb, 8'hbb, 8'hbc, 8'hbd,
      8'hbe, 8'hbf, 8'hff, 8'h60
   };

endpackage

### hw/rtl/escape_sequence_symbol_translator_top.sv
// Top level of the escape sequence symbol translator.
// Depends on esst_pkg and instantiates esst_lookup for the symbol table match.
//
// The block takes one source character per request on the req_ channel and returns
// at most one result per request on the rsp_ channel. Plain characters pass through,
// a doubled backslash gives one backslash, and a backslash followed by two characters
// is looked up in the symbol table. An unknown escape returns kind 2 with no character.
// A zero character ends the string and returns kind 1 with the number of characters
// emitted since the previous end, saturating.
//
// A request is decoded in the cycle it is accepted and its result sits in the output
// register from the next cycle. The table match is a parallel compare of all entries,
// so one request is accepted every cycle unless a stalled result holds req_ready low.
// A backslash, and the first character of an escape, return no result.
//
// When the receiver stalls, the output register holds its result and req_ready falls,
// unless the held result is being taken in the same cycle. Requests that yield no
// result still need that free slot. Reset returns the decoder to the idle phase,
// clears the character count and empties the output register.
module escape_sequence_symbol_translator_top #(
   parameter int LENGTH_BITS = esst_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_out_length
);
   import esst_pkg::*;

   localparam int EXT_BITS = LENGTH_BITS + OUT_LENGTH_BITS;

   // Decoder state.
   phase_type              phase_ff, phase_in;
   logic [7:0]             first_ff, first_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 byte_ff, byte_in;
   kind_type                   kind_ff, kind_in;
   logic [OUT_LENGTH_BITS-1:0] length_ff, length_in;

   logic                       accept;
   logic                       load;
   logic                       fold;
   logic [7:0]                 second;
   lookup_type                 match;
   logic [EXT_BITS-1:0]        count_ext;
   logic [OUT_LENGTH_BITS-1:0] count_sat;
   logic [LENGTH_BITS-1:0]     count_inc;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Greek lookups fold an upper-case second letter to lower case.
   assign fold   = (first_ff == CHAR_GREEK) && (req_in_byte >= CHAR_UPPER_A)
                   && (req_in_byte <= CHAR_UPPER_Z);
   assign second = fold ? req_in_byte + CASE_SHIFT : req_in_byte;

   esst_lookup u_lookup (
      .code   ({first_ff, second}),
      .result (match)
   );

   // The reported length clamps the count to the width of the output field.
   assign count_ext = EXT_BITS'(count_ff);
   assign count_sat = (|count_ext[EXT_BITS-1:OUT_LENGTH_BITS]) ? '1
                      : count_ext[OUT_LENGTH_BITS-1:0];
   assign count_inc = (&count_ff) ? count_ff : count_ff + 1'b1;

   always_comb begin
      phase_in  = phase_ff;
      first_in  = first_ff;
      count_in  = count_ff;
      load      = 1'b0;
      byte_in   = byte_ff;
      kind_in   = kind_ff;
      length_in = length_ff;

      if (accept) begin
         if (req_in_byte == CHAR_NUL) begin
            // End of string, also when an escape was pending.
            load      = 1'b1;
            byte_in   = CHAR_NUL;
            kind_in   = KIND_END;
            length_in = count_sat;
            phase_in  = PH_IDLE;
            first_in  = CHAR_NUL;
            count_in  = '0;
         end else begin
            unique case (phase_ff)
               PH_ESC: begin
                  if (req_in_byte == CHAR_BACKSLASH) begin
                     load      = 1'b1;
                     byte_in   = CHAR_BACKSLASH;
                     kind_in   = KIND_CHAR;
                     length_in = '0;
                     count_in  = count_inc;
                     phase_in  = PH_IDLE;
                  end else begin
                     first_in = (req_in_byte == CHAR_GREEK || req_in_byte == CHAR_GREEK_UP
                                 || req_in_byte == CHAR_STAR) ? CHAR_GREEK : req_in_byte;
                     phase_in = PH_CODE;
                  end
               end
               PH_CODE: begin
                  load      = 1'b1;
                  length_in = '0;
                  phase_in  = PH_IDLE;
                  if (match.hit) begin
                     byte_in  = fold ? match.sym - CASE_SHIFT : match.sym;
                     kind_in  = KIND_CHAR;
                     count_in = count_inc;
                  end else begin
                     byte_in = CHAR_NUL;
                     kind_in = KIND_UNKNOWN;
                  end
               end
               default: begin
                  // Idle, and the unused phase code behaves as idle.
                  if (req_in_byte == CHAR_BACKSLASH) begin
                     phase_in = PH_ESC;
                  end else begin
                     load      = 1'b1;
                     byte_in   = req_in_byte;
                     kind_in   = KIND_CHAR;
                     length_in = '0;
                     count_in  = count_inc;
                     phase_in  = PH_IDLE;
                  end
               end
            endcase
         end
      end

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         first_ff     <= CHAR_NUL;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         first_ff     <= first_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_in;
         kind_ff   <= kind_in;
         length_ff <= length_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_out_length = length_ff;

   // An end of string or a dropped escape never carries a character.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_CHAR) |-> rsp_out_byte == CHAR_NUL)
      else $error("non-character result carries a character");

   // Only an end of string reports a length.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_END) |-> rsp_out_length == '0)
      else $error("length reported outside an end of string");

   // A zero character always yields an end of string in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_in_byte == CHAR_NUL) |=> (rsp_valid && rsp_kind == KIND_END))
      else $error("zero character did not end the string");

   // The character count is cleared by every end of string.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_in_byte == CHAR_NUL) |=> (count_ff == '0 && phase_ff == PH_IDLE))
      else $error("decoder state not cleared at end of string");

endmodule

### hw/rtl/esst_lookup.sv
// Symbol code matcher: compares a two-character code against every table entry at once.
// Depends on esst_pkg for the code and symbol tables.
module esst_lookup (
   input  logic [15:0]          code,
   output esst_pkg::lookup_type result
);
   import esst_pkg::*;

   // Walk from the last entry to the first so that the earliest match wins.
   always_comb begin
      result = '0;
      for (int i = TSIZE - 1; i >= 0; i--) begin
         if (CODE_ROM[i] == code) begin
            result.hit = 1'b1;
            result.sym = SYM_ROM[i];
         end
      end
   end

endmodule
